// ===== design/pbrgb_pkg.sv =====
package pbrgb_pkg;

	// Store geometry
	localparam int MAX_COLUMNS = 256;
	localparam int MAX_PLANES  = 3;
	localparam int STORE_DEPTH = MAX_COLUMNS * MAX_PLANES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LOAD_W      = $clog2(STORE_DEPTH + 1);
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);

	// Field widths
	localparam int PLANE_W  = 2;
	localparam int ROW_W    = 3;
	localparam int PAGE_W   = 7;
	localparam int SPAN_W   = 10;
	localparam int HEIGHT_W = 11;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 64;

	localparam logic [PLANE_W-1:0]  COLOUR_BITS_RST   = 2'd1;
	localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = 11'd240;

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_NEXT  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_PAL_LO        = 2'd0,
		REG_PAL_HI        = 2'd1,
		REG_COLOUR_BITS   = 2'd2,
		REG_SCREEN_HEIGHT = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_HI,
		ST_LO
	} state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [7:0]        byte_value;
		logic [SPAN_W-1:0] column_start;
		logic [SPAN_W-1:0] column_end;
		logic [PAGE_W-1:0] page_index;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       high_half;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [63:0]         palette_low;
		logic [63:0]         palette_high;
		logic [PLANE_W-1:0]  colour_bits;
		logic [HEIGHT_W-1:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic begin_page;
		logic load;
		logic deactivate;
		logic start_emit;
		logic rd;
		logic push_hi;
		logic push_lo;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic row_ok;
		logic last_plane;
		logic out_free;
	} sts_t;

endpackage

// ===== design/pbrgb_regs.sv =====
module pbrgb_regs import pbrgb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [63:0]         pal_lo_q;
	logic [63:0]         pal_hi_q;
	logic [PLANE_W-1:0]  colour_bits_q;
	logic [HEIGHT_W-1:0] height_q;
	reg_idx_t            idx;
	logic                wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_lo_q      <= '0;
			pal_hi_q      <= '0;
			colour_bits_q <= COLOUR_BITS_RST;
			height_q      <= SCREEN_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_PAL_LO:        pal_lo_q      <= pwdata;
				REG_PAL_HI:        pal_hi_q      <= pwdata;
				REG_COLOUR_BITS:   colour_bits_q <= pwdata[PLANE_W-1:0];
				REG_SCREEN_HEIGHT: height_q      <= pwdata[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PAL_LO:        prdata = pal_lo_q;
			REG_PAL_HI:        prdata = pal_hi_q;
			REG_COLOUR_BITS:   prdata = PDATA_W'(colour_bits_q);
			REG_SCREEN_HEIGHT: prdata = PDATA_W'(height_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.palette_low   = pal_lo_q;
	assign cfg.palette_high  = pal_hi_q;
	assign cfg.colour_bits   = colour_bits_q;
	assign cfg.screen_height = height_q;

endmodule

// ===== design/pbrgb_ctrl.sv =====
module pbrgb_ctrl import pbrgb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] action,
	input  sts_t       sts,
	output logic       item_ready,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && action == ACT_NEXT && sts.active && sts.row_ok) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (sts.last_plane) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: state_d = ST_HI;
			ST_HI: begin
				if (sts.out_free) begin
					state_d = ST_LO;
				end
			end
			ST_LO: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (action)
						ACT_BEGIN: cmd.begin_page = 1'b1;
						ACT_LOAD:  cmd.load = 1'b1;
						ACT_NEXT: begin
							if (sts.active) begin
								cmd.start_emit = sts.row_ok;
								cmd.deactivate = !sts.row_ok;
							end
						end
						default: ;
					endcase
				end
			end
			ST_READ: cmd.rd = 1'b1;
			ST_WAIT: ;
			ST_HI:   cmd.push_hi = sts.out_free;
			ST_LO:   cmd.push_lo = sts.out_free;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !(cmd.rd || cmd.push_hi || cmd.push_lo))
		else $error("pbrgb_ctrl: datapath command issued while taking items");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_emit |=> state_q == ST_READ)
		else $error("pbrgb_ctrl: emit started without plane reads");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |=> state_q == ST_HI)
		else $error("pbrgb_ctrl: read data wait not followed by high byte");

endmodule

// ===== design/pbrgb_dp.sv =====
module pbrgb_dp import pbrgb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cfg_t    cfg,
	input  cmd_t    cmd,
	output sts_t    sts,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] mem_q;

	logic [LOAD_W-1:0]  load_pos_q;
	logic [CNT_W-1:0]   col_count_q;
	logic [PAGE_W-1:0]  page_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               active_q;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic [PLANE_W-1:0] plane_cnt_q;
	logic               rd_vld_s1;
	logic [PLANE_W-1:0] rd_plane_s1;
	logic [2:0]         index_q;
	logic               result_valid_q;
	result_t            result_q;

	logic [PLANE_W-1:0]    planes;
	logic [SPAN_W-1:0]     col_hi;
	logic [SPAN_W:0]       span;
	logic [CNT_W-1:0]      begin_count;
	logic [PAGE_W+ROW_W-1:0] row_num;
	logic                  row_ok;
	logic                  next_row_ok;
	logic                  page_ok;
	logic                  final_col;
	logic                  final_row;
	logic                  is_last;
	logic [ADDR_W-1:0]     rd_base;
	logic [63:0]           pal_word;
	logic [15:0]           colour;
	logic                  store_room;

	assign planes = (cfg.colour_bits == '0) ? PLANE_W'(1) : cfg.colour_bits;

	// Reversed window collapses to one column; wide window saturates
	assign col_hi = (item.column_end < item.column_start) ? item.column_start : item.column_end;
	assign span   = {1'b0, col_hi - item.column_start} + (SPAN_W+1)'(1);
	assign begin_count = (span > (SPAN_W+1)'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : CNT_W'(span);

	assign row_num     = {page_q, row_q};
	assign row_ok      = {1'b0, row_num} < cfg.screen_height;
	assign next_row_ok = ({1'b0, row_num} + HEIGHT_W'(1)) < cfg.screen_height;
	assign page_ok     = {1'b0, item.page_index, ROW_W'(0)} < cfg.screen_height;

	assign final_col = (CNT_W'(col_q) + CNT_W'(1)) >= col_count_q;
	assign final_row = (row_q == '1) || !next_row_ok;
	assign is_last   = final_col && final_row;

	assign rd_base    = ADDR_W'(col_q) * ADDR_W'(planes);
	assign store_room = load_pos_q < LOAD_W'(STORE_DEPTH);

	assign pal_word = index_q[2] ? cfg.palette_high : cfg.palette_low;
	assign colour   = pal_word[{index_q[1:0], 4'b0} +: 16];

	assign sts.active     = active_q;
	assign sts.row_ok     = row_ok;
	assign sts.last_plane = plane_cnt_q >= (planes - PLANE_W'(1));
	assign sts.out_free   = !result_valid_q || result_ready;

	// Plane store
	always_ff @(posedge clk) begin
		if (cmd.load && store_room) begin
			mem[load_pos_q[ADDR_W-1:0]] <= item.byte_value;
		end
		if (cmd.rd) begin
			mem_q <= mem[rd_addr_q];
		end
	end

	// Window and cursors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q  <= '0;
			col_count_q <= '0;
			page_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			active_q    <= 1'b0;
			plane_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
			if (cmd.begin_page) begin
				col_count_q <= begin_count;
				page_q      <= item.page_index;
				load_pos_q  <= '0;
				row_q       <= '0;
				col_q       <= '0;
				active_q    <= page_ok;
			end
			if (cmd.load && store_room) begin
				load_pos_q <= load_pos_q + LOAD_W'(1);
			end
			if (cmd.deactivate) begin
				active_q <= 1'b0;
			end
			if (cmd.start_emit) begin
				plane_cnt_q <= '0;
			end else if (cmd.rd) begin
				plane_cnt_q <= plane_cnt_q + PLANE_W'(1);
			end
			if (cmd.push_lo) begin
				if (is_last) begin
					active_q <= 1'b0;
				end else if (final_col) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// Read address and palette index gather
	always_ff @(posedge clk) begin
		rd_plane_s1 <= plane_cnt_q;
		if (cmd.start_emit) begin
			rd_addr_q <= rd_base;
		end else if (cmd.rd) begin
			rd_addr_q <= rd_addr_q + ADDR_W'(1);
		end
		if (cmd.start_emit) begin
			index_q <= '0;
		end else if (rd_vld_s1) begin
			for (int p = 0; p < MAX_PLANES; p++) begin
				if (rd_plane_s1 == PLANE_W'(p)) begin
					index_q[p] <= mem_q[row_q];
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.push_hi || cmd.push_lo) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_hi) begin
			result_q.out_byte  <= colour[15:8];
			result_q.high_half <= 1'b1;
			result_q.last      <= 1'b0;
		end else if (cmd.push_lo) begin
			result_q.out_byte  <= colour[7:0];
			result_q.high_half <= 1'b0;
			result_q.last      <= is_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_hi || cmd.push_lo) |-> (!result_valid_q || result_ready))
		else $error("pbrgb_dp: output register overwritten before transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.high_half) |-> !result_q.last)
		else $error("pbrgb_dp: high byte marked last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_ready) |=> (result_valid_q && $stable(result_q)))
		else $error("pbrgb_dp: stalled output byte changed or dropped");

endmodule

// ===== design/page_bitplane_to_rgb565_expander.sv =====
// Page bitplane to RGB565 expander.
//
// Input channel (item_valid/item_ready/item): one command per transfer.
//   begin sets the column window and page and clears the load and pixel cursors;
//   load writes one plane byte to the next store position while there is room;
//   next emits one pixel as two output transfers, high byte then low byte.
// Output channel (result_valid/result_ready/result): one RGB565 byte per
//   transfer, high_half flags the upper byte, last flags the page's final byte.
// Configuration: APB-style, 64-bit data, registers at 8-byte steps: palette
//   low, palette high, colour_bits, screen_height. pready is tied high.
// Sequencing: a next item reads the plane store once per bit plane through the
//   single read port, waits for the read data, then pushes the high byte and
//   the low byte, each once the output register is free. begin, load and next
//   items that emit nothing leave the sequencer idle and ready for items.
// When the receiver stalls, the low byte waits in the output register while
//   the block already takes the next item; a further pixel holds until it drains.
// Reset clears cursors and output valid, loads register defaults (colour_bits 1,
//   screen_height 240); the plane store comes up unwritten, no clearing pass.
module page_bitplane_to_rgb565_expander import pbrgb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_ready,
	output result_t            result
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// Register file
	pbrgb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: decode items, step through plane reads and byte pushes
	pbrgb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.action     (item.action),
		.sts        (sts),
		.item_ready (item_ready),
		.cmd        (cmd)
	);

	// Plane store, cursors, palette lookup and output register
	pbrgb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
